@@ src/tccl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccl_pkg
// Shared types and constants for the thermal charge-current limiter.
// ----------------------------------------------------------------------------
package tccl_pkg;

  // Default ring depth
  localparam int WINDOW_DEF = 5;

  // Valid reading window in kelvin: -29 C .. 124 C
  localparam logic [8:0] KELVIN_MIN    = 9'd244;
  localparam logic [8:0] KELVIN_MAX    = 9'd397;
  localparam logic [9:0] KELVIN_OFFSET = 10'd273;

  // Thresholds in Celsius
  localparam logic signed [7:0] T_CUTOFF = 8'sd90;
  localparam logic signed [7:0] T_RISE3  = 8'sd85;
  localparam logic signed [7:0] T_RISE2  = 8'sd75;
  localparam logic signed [7:0] T_RISE1  = 8'sd65;
  localparam logic signed [7:0] T_FALL1  = 8'sd60;
  localparam logic signed [7:0] T_FALL2  = 8'sd66;
  localparam logic signed [7:0] T_FALL3  = 8'sd76;

  // Zone codes
  localparam logic [2:0] ZONE_0    = 3'd0;
  localparam logic [2:0] ZONE_1    = 3'd1;
  localparam logic [2:0] ZONE_2    = 3'd2;
  localparam logic [2:0] ZONE_3    = 3'd3;
  localparam logic [2:0] ZONE_OFF  = 3'd4;
  localparam logic [2:0] ZONE_NONE = 3'd5;

  // Zone current limits, mA
  localparam logic [15:0] LIMIT_ZONE0 = 16'd5000;
  localparam logic [15:0] LIMIT_ZONE1 = 16'd2500;
  localparam logic [15:0] LIMIT_ZONE2 = 16'd1800;
  localparam logic [15:0] LIMIT_ZONE3 = 16'd1000;
  localparam logic [15:0] LIMIT_OFF   = 16'd0;
  localparam logic [15:0] LIMIT_NONE  = 16'hFFFF;

  typedef struct packed {
    logic [8:0]  temp_kelvin;
    logic        battery_responsive;
    logic        bad_temperature;
    logic        system_active;
    logic [15:0] req_current;
    logic        discharging;
  } in_word_t;

  typedef struct packed {
    logic [15:0] limited_current;
    logic        clear_want_charge;
    logic        force_idle;
    logic [2:0]  zone;
  } out_word_t;

endpackage

@@ src/thermal_charge_current_limiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_charge_current_limiter
// Averages valid temperature readings over a ring and caps the charge
// current by thermal zone, using one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | ports                      | word
//  --------+-----------+----------------------------+------------
//  in      | input     | in_valid, in_stall, in_word | in_word_t
//  out     | output    | out_valid, out_stall, out_word | out_word_t
//
//  A stored reading goes through the accept cycle, WINDOW adds, two
//  setup steps, one multiply by the reciprocal of 2 * WINDOW, a sign
//  step and the result load. The adds, setup and sign steps all go
//  through the one shared adder. An ignored reading goes from the
//  accept cycle straight to the result load. in_stall is high while a
//  word is in work. Reset is synchronous and clears the ring, pointer
//  and previous average. The result sits in an output register; a
//  stalled result only delays the next result load until it is taken.
// ----------------------------------------------------------------------------
module thermal_charge_current_limiter #(
  parameter int WINDOW = tccl_pkg::WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tccl_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output tccl_pkg::out_word_t out_word
);
  import tccl_pkg::*;

  localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = 8 + $clog2(WINDOW);
  localparam int NUM_W   = SUM_W + 2;
  localparam int DIV     = 2 * WINDOW;
  localparam int DIV_SH  = NUM_W + $clog2(DIV);
  localparam int RECIP_W = NUM_W + 2;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << DIV_SH) + DIV - 1) / DIV);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SUM  = 7'b0000010,
    ST_PREP = 7'b0000100,
    ST_ABS  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_SIGN = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  in_word_t          word_r, word_nxt;
  logic              pass_r, pass_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic [NUM_W-1:0]  dq_r, dq_nxt;
  logic              neg_r, neg_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic signed [7:0] avg_r, avg_nxt;
  logic signed [7:0] prev_r, prev_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              accept;
  logic              temp_ok;
  logic [9:0]        celsius;
  logic              ring_wr;
  logic [7:0]        ring_rd;
  logic              ring_last_nz;
  logic [IDX_W-1:0]  ring_ptr;
  logic [NUM_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_sub, alu_carry;
  logic [NUM_W+RECIP_W-1:0] prod;
  logic              fin_load;
  out_word_t         zone_word;

  // Input qualification
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign temp_ok  = in_word.battery_responsive &&
                    (in_word.temp_kelvin >= KELVIN_MIN) &&
                    (in_word.temp_kelvin <= KELVIN_MAX);
  assign celsius  = {1'b0, in_word.temp_kelvin} - KELVIN_OFFSET;
  assign ring_wr  = accept && temp_ok;

  tccl_ring #(
    .WINDOW (WINDOW),
    .IDX_W  (IDX_W)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en_i   (ring_wr),
    .wr_data_i (celsius[7:0]),
    .rd_idx_i  (idx_r),
    .rd_data_o (ring_rd),
    .last_nz_o (ring_last_nz),
    .ptr_o     (ring_ptr)
  );

  // Magnitude over 2 * WINDOW as a multiply by the rounded-up reciprocal;
  // exact for every magnitude below 2^(NUM_W-1)
  assign prod = {{RECIP_W{1'b0}}, dq_r} * {{NUM_W{1'b0}}, RECIP};

  // Shared adder operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_SUM: begin
        alu_a = acc_r;
        alu_b = {{(NUM_W-8){ring_rd[7]}}, ring_rd};
      end
      ST_PREP: begin
        alu_a = {acc_r[NUM_W-2:0], 1'b0};
        alu_b = NUM_W'(WINDOW);
      end
      ST_ABS, ST_SIGN: begin
        alu_b   = dq_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  tccl_alu #(
    .W (NUM_W)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  tccl_zone u_zone (
    .avg_i   (avg_r),
    .prev_i  (prev_r),
    .apply_i (!pass_r && ring_last_nz),
    .word_i  (word_r),
    .word_o  (zone_word)
  );

  assign fin_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    pass_nxt      = pass_r;
    acc_nxt       = acc_r;
    dq_nxt        = dq_r;
    neg_nxt       = neg_r;
    idx_nxt       = idx_r;
    avg_nxt       = avg_r;
    prev_nxt      = prev_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          word_nxt  = in_word;
          pass_nxt  = !temp_ok;
          acc_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = temp_ok ? ST_SUM : ST_FIN;
        end
      end
      ST_SUM: begin
        acc_nxt = alu_res;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_W'(WINDOW - 1)) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        dq_nxt    = alu_res;
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        // Divide the magnitude, fix the sign afterward
        neg_nxt   = dq_r[NUM_W-1];
        dq_nxt    = dq_r[NUM_W-1] ? alu_res : dq_r;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Quotient magnitude always fits in 8 bits
        dq_nxt    = {{(NUM_W-8){1'b0}}, prod[DIV_SH +: 8]};
        state_nxt = ST_SIGN;
      end
      ST_SIGN: begin
        avg_nxt   = neg_r ? alu_res[7:0] : dq_r[7:0];
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = pass_r ? out_word_t'{limited_current:   word_r.req_current,
                                               clear_want_charge: 1'b0,
                                               force_idle:        1'b0,
                                               zone:              ZONE_NONE}
                                 : zone_word;
          if (!pass_r) begin
            prev_nxt = avg_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    pass_r     <= pass_nxt;
    acc_r      <= acc_nxt;
    dq_r       <= dq_nxt;
    neg_r      <= neg_nxt;
    idx_r      <= idx_nxt;
    avg_r      <= avg_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef ASSERT_OFF
  // Ring pointer never leaves the window
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ring_ptr <= IDX_W'(WINDOW - 1))
    else $error("ring pointer out of range");

  // An accepted word starts either the sum or the pass-through result
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SUM || state_r == ST_FIN))
    else $error("bad state after accept");

  // Out-of-range zone always cuts the current to zero
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.zone == ZONE_OFF) |-> (out_word.limited_current == 16'd0))
    else $error("out-of-range zone with nonzero current");

  // Want-charge is cleared exactly in the out-of-range zone
  a_clear_want: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.clear_want_charge == (out_word.zone == ZONE_OFF)))
    else $error("clear_want_charge mismatch with zone");
`endif

endmodule

@@ src/tccl_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccl_alu
// Shared adder/subtractor used for summing, scaling and sign handling.
// ----------------------------------------------------------------------------
module tccl_alu #(
  parameter int W = 13
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output logic         carry_o
);

  logic [W:0] full;

  // a + b, or a - b as a + ~b + 1; carry set on subtract means a >= b
  assign full    = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + {{W{1'b0}}, sub_i};
  assign res_o   = full[W-1:0];
  assign carry_o = full[W];

endmodule

@@ src/tccl_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccl_ring
// Ring of Celsius samples with write pointer; one indexed read port.
// ----------------------------------------------------------------------------
module tccl_ring #(
  parameter int WINDOW = 5,
  parameter int IDX_W  = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en_i,
  input  logic [7:0]       wr_data_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [7:0]       rd_data_o,
  output logic             last_nz_o,
  output logic [IDX_W-1:0] ptr_o
);

  logic [7:0]       ring_r [WINDOW];
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] ptr_nxt;

  // Pointer wraps after the last slot
  always_comb begin
    if (ptr_r == IDX_W'(WINDOW - 1)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        ring_r[i] <= '0;
      end
    end else if (wr_en_i) begin
      ring_r[ptr_r] <= wr_data_i;
      ptr_r         <= ptr_nxt;
    end
  end

  assign rd_data_o = ring_r[rd_idx_i];
  assign last_nz_o = (ring_r[WINDOW-1] != 8'd0);
  assign ptr_o     = ptr_r;

endmodule

@@ src/tccl_zone.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccl_zone
// Zone selection from the average and flags, and current capping.
// ----------------------------------------------------------------------------
module tccl_zone (
  input  logic signed [7:0] avg_i,
  input  logic signed [7:0] prev_i,
  input  logic              apply_i,
  input  tccl_pkg::in_word_t word_i,
  output tccl_pkg::out_word_t word_o
);
  import tccl_pkg::*;

  logic        rising;
  logic [2:0]  zone;
  logic [15:0] limit;

  assign rising = (prev_i <= avg_i);

  // Zone ladders
  always_comb begin
    if (!apply_i) begin
      zone = ZONE_NONE;
    end else if (word_i.bad_temperature || avg_i >= T_CUTOFF) begin
      zone = ZONE_OFF;
    end else if (!word_i.system_active) begin
      zone = ZONE_0;
    end else if (rising) begin
      if (avg_i >= T_RISE3) begin
        zone = ZONE_3;
      end else if (avg_i >= T_RISE2) begin
        zone = ZONE_2;
      end else if (avg_i >= T_RISE1) begin
        zone = ZONE_1;
      end else begin
        zone = ZONE_0;
      end
    end else begin
      if (avg_i < T_FALL1) begin
        zone = ZONE_0;
      end else if (avg_i < T_FALL2) begin
        zone = ZONE_1;
      end else if (avg_i < T_FALL3) begin
        zone = ZONE_2;
      end else begin
        zone = ZONE_3;
      end
    end
  end

  // Zone limit
  always_comb begin
    unique case (zone)
      ZONE_0:   limit = LIMIT_ZONE0;
      ZONE_1:   limit = LIMIT_ZONE1;
      ZONE_2:   limit = LIMIT_ZONE2;
      ZONE_3:   limit = LIMIT_ZONE3;
      ZONE_OFF: limit = LIMIT_OFF;
      default:  limit = LIMIT_NONE;
    endcase
  end

  always_comb begin
    word_o.limited_current   = (word_i.req_current < limit) ?
                               word_i.req_current : limit;
    word_o.clear_want_charge = (zone == ZONE_OFF);
    word_o.force_idle        = (zone == ZONE_OFF) && !word_i.discharging;
    word_o.zone              = zone;
  end

endmodule
